// ===== rtl/cst_pkg.sv =====
// Shared types, codes and defaults for the compacting set table.
`timescale 1ns / 1ps
`default_nettype none

package cst_pkg;

  localparam int OP_W         = 2;
  localparam int ELEM_FIELD_W = 32;
  localparam int STATUS_W     = 3;
  localparam int SLOT_FIELD_W = 7;

  localparam int DEF_CAPACITY      = 128;
  localparam int DEF_ELEMENT_WIDTH = 32;

  // operation codes
  localparam logic [OP_W-1:0] OP_BAD  = 2'd0;
  localparam logic [OP_W-1:0] OP_ADD  = 2'd1;
  localparam logic [OP_W-1:0] OP_DEL  = 2'd2;
  localparam logic [OP_W-1:0] OP_FIND = 2'd3;

  // status codes
  localparam logic [STATUS_W-1:0] STATUS_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL     = 3'd1;
  localparam logic [STATUS_W-1:0] STATUS_DUP      = 3'd2;
  localparam logic [STATUS_W-1:0] STATUS_NOTFOUND = 3'd3;
  localparam logic [STATUS_W-1:0] STATUS_BADOP    = 3'd4;

  typedef struct packed {
    logic [OP_W-1:0]         operation;
    logic [ELEM_FIELD_W-1:0] element_value;
  } cst_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0]     status;
    logic [SLOT_FIELD_W-1:0] slot_index;
  } cst_rsp_t;

  // per-cell control from the sequencer
  typedef struct packed {
    logic cmp;    // capture compare result
    logic shift;  // take the upper neighbor's entry
    logic load;   // write the broadcast key
  } cst_cell_ctl_t;

endpackage : cst_pkg

`default_nettype wire

// ===== rtl/cst_cell.sv =====
// One slot of the set table: stored entry, compare and shift-down.
`timescale 1ns / 1ps
`default_nettype none

module cst_cell
  import cst_pkg::*;
#(
  parameter int ELEMENT_WIDTH = DEF_ELEMENT_WIDTH
) (
  input  wire                      clk,
  input  cst_cell_ctl_t            ctl,
  input  wire  [ELEMENT_WIDTH-1:0] key,
  input  wire  [ELEMENT_WIDTH-1:0] neighbor,
  input  wire                      occupied,
  output logic [ELEMENT_WIDTH-1:0] entry,
  output logic                     match
);

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      entry <= key;
    end else if (ctl.shift) begin
      entry <= neighbor;
    end
  end

  // only live slots may hit
  always_ff @(posedge clk) begin
    if (ctl.cmp) begin
      match <= occupied && (entry == key);
    end
  end

endmodule : cst_cell

`default_nettype wire

// ===== rtl/compacting_set_table.sv =====
// Top level of the compacting set table: sequencer, slot encoder and cell row.
`timescale 1ns / 1ps
`default_nettype none

// Compacting set table. Holds up to CAPACITY distinct elements of
// ELEMENT_WIDTH bits, packed in insertion order in slots 0 .. count-1, one
// slot per cell of a row of cells. Every request transaction (add, delete,
// find, or the unused code reported as bad operation) yields exactly one
// response transaction with a status and a slot. Timing: a request is
// registered at accept, all cells compare their entry against the key in
// the next cycle, and in the cycle after that the table updates (append at
// slot count, or every cell at or above the removed slot takes its upper
// neighbor's entry) and the response is registered. A new request is taken
// in that same update cycle. A response that is not taken holds the row in
// its update cycle until the output register frees. Slots wider than 7 bits
// are reported by their low 7 bits. There is no clearing pass after reset;
// only the count, the state and the response valid are cleared.
module compacting_set_table
  import cst_pkg::*;
#(
  parameter int CAPACITY      = DEF_CAPACITY,
  parameter int ELEMENT_WIDTH = DEF_ELEMENT_WIDTH
) (
  input  wire       clk,
  input  wire       rst,
  input  wire       req_valid,
  output logic      req_stall,
  input  cst_req_t  req,
  output logic      rsp_valid,
  input  wire       rsp_stall,
  output cst_rsp_t  rsp
);

  localparam int SLOT_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int COUNT_W = $clog2(CAPACITY + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CMP  = 2'd1;
  localparam logic [1:0] S_UPD  = 2'd2;

  logic [1:0]               state;
  logic [1:0]               state_next;
  logic [COUNT_W-1:0]       count;
  logic [OP_W-1:0]          op;
  logic [ELEMENT_WIDTH-1:0] key;
  logic [ELEMENT_WIDTH-1:0] key_in;

  logic [ELEMENT_WIDTH-1:0] entry [CAPACITY];
  logic [CAPACITY-1:0]      match;
  logic [CAPACITY-1:0]      occupied;
  cst_cell_ctl_t            ctl [CAPACITY];

  logic                     accept;
  logic                     go;
  logic                     any_match;
  logic                     full;
  logic                     add_go;
  logic                     del_go;
  logic [SLOT_W-1:0]        slot;
  logic [STATUS_W-1:0]      status;
  logic [SLOT_W+SLOT_FIELD_W-1:0] slot_wide;

  // key is the low ELEMENT_WIDTH bits of the field, zero-extended if wider
  generate
    if (ELEMENT_WIDTH <= ELEM_FIELD_W) begin : g_key_narrow
      assign key_in = req.element_value[ELEMENT_WIDTH-1:0];
    end else begin : g_key_wide
      assign key_in = {{(ELEMENT_WIDTH-ELEM_FIELD_W){1'b0}}, req.element_value};
    end
  endgenerate

  // update cycle completes once the output register can take the response
  assign go        = (state == S_UPD) && (!rsp_valid || !rsp_stall);
  assign req_stall = !((state == S_IDLE) || go);
  assign accept    = req_valid && !req_stall;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) state_next = S_CMP;
      end
      S_CMP: begin
        state_next = S_UPD;
      end
      S_UPD: begin
        if (go) state_next = accept ? S_CMP : S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op  <= req.operation;
      key <= key_in;
    end
  end

  // Elements are distinct, so at most one cell hits: OR of hit indexes
  // gives the slot without a priority search.
  always_comb begin
    slot = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (match[i]) slot = slot | SLOT_W'(i);
    end
  end

  assign any_match = |match;
  assign full      = (count >= COUNT_W'(CAPACITY));

  always_comb begin
    status = STATUS_OK;
    add_go = 1'b0;
    del_go = 1'b0;
    slot_wide = '0;
    unique case (op)
      OP_ADD: begin
        if (full) begin
          status = STATUS_FULL;
        end else if (any_match) begin
          status = STATUS_DUP;
        end else begin
          add_go    = go;
          slot_wide = (SLOT_W+SLOT_FIELD_W)'(count[SLOT_W-1:0]);
        end
      end
      OP_DEL: begin
        if (any_match) begin
          del_go    = go;
          slot_wide = (SLOT_W+SLOT_FIELD_W)'(slot);
        end else begin
          status = STATUS_NOTFOUND;
        end
      end
      OP_FIND: begin
        if (any_match) begin
          slot_wide = (SLOT_W+SLOT_FIELD_W)'(slot);
        end else begin
          status = STATUS_NOTFOUND;
        end
      end
      OP_BAD: begin
        status = STATUS_BADOP;
      end
      default: begin
        status = STATUS_BADOP;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (add_go) begin
      count <= count + COUNT_W'(1);
    end else if (del_go) begin
      count <= count - COUNT_W'(1);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (go) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      rsp.status     <= status;
      rsp.slot_index <= slot_wide[SLOT_FIELD_W-1:0];
    end
  end

  // cell row
  generate
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [ELEMENT_WIDTH-1:0] nb;

      if (i == CAPACITY - 1) begin : g_top
        assign nb = entry[i];
      end else begin : g_mid
        assign nb = entry[i+1];
      end

      assign occupied[i] = (COUNT_W'(i) < count);
      assign ctl[i].cmp   = (state == S_CMP);
      assign ctl[i].load  = add_go && (COUNT_W'(i) == count);
      assign ctl[i].shift = del_go && (SLOT_W'(i) >= slot);

      cst_cell #(
        .ELEMENT_WIDTH(ELEMENT_WIDTH)
      ) u_cell (
        .clk      (clk),
        .ctl      (ctl[i]),
        .key      (key),
        .neighbor (nb),
        .occupied (occupied[i]),
        .entry    (entry[i]),
        .match    (match[i])
      );
    end
  endgenerate

  // count stays within the table
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= COUNT_W'(CAPACITY))
    else $error("entry count above capacity");

  // stored elements are distinct, so the compare hits at most one cell
  a_single_hit: assert property (@(posedge clk) disable iff (rst)
    (state == S_UPD) |-> $onehot0(match))
    else $error("more than one cell matched the key");

  // an accepted request always goes to the compare cycle
  a_accept_cmp: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == S_CMP))
    else $error("accepted transaction not compared");

  // table size moves only when an update completes
  a_count_hold: assert property (@(posedge clk) disable iff (rst)
    !go |=> $stable(count))
    else $error("entry count changed outside an update");

endmodule : compacting_set_table

`default_nettype wire

// ===== sim/cst_checker.sv =====
// Response checker for the compacting set table: predicts and compares every transaction.
`timescale 1ns / 1ps

module cst_checker
  import cst_pkg::*;
#(
  parameter int CAPACITY      = DEF_CAPACITY,
  parameter int ELEMENT_WIDTH = DEF_ELEMENT_WIDTH
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         req_valid,
  input  wire         req_stall,
  input  cst_req_t    req,
  input  wire         rsp_valid,
  input  wire         rsp_stall,
  input  cst_rsp_t    rsp,
  output int unsigned errors,
  output int unsigned outstanding,
  output int unsigned n_ok,
  output int unsigned n_full,
  output int unsigned n_dup,
  output int unsigned n_miss,
  output int unsigned n_badop,
  output int unsigned peak_fill
);

  // shadow of the table contents, packed in insertion order
  logic [ELEMENT_WIDTH-1:0] members [CAPACITY];
  int unsigned              fill;
  cst_rsp_t                 expected_rsp_q [$];

  initial begin
    errors    = 0;
    n_ok      = 0;
    n_full    = 0;
    n_dup     = 0;
    n_miss    = 0;
    n_badop   = 0;
    peak_fill = 0;
    fill      = 0;
    outstanding = 0;
  end

  // first slot holding elem, or -1
  function automatic int member_slot(input logic [ELEMENT_WIDTH-1:0] elem);
    for (int i = 0; i < int'(fill); i++) begin
      if (members[i] == elem) return i;
    end
    return -1;
  endfunction

  task automatic apply_set_op(input cst_req_t t, output cst_rsp_t r);
    logic [ELEMENT_WIDTH-1:0] elem;
    int                       hit;
    elem         = ELEMENT_WIDTH'(t.element_value);
    hit          = member_slot(elem);
    r.status     = STATUS_OK;
    r.slot_index = '0;
    case (t.operation)
      OP_ADD: begin
        if (fill >= CAPACITY) begin
          r.status = STATUS_FULL;
        end else if (hit >= 0) begin
          r.status = STATUS_DUP;
        end else begin
          members[fill] = elem;
          r.slot_index  = SLOT_FIELD_W'(fill);
          fill++;
        end
      end
      OP_DEL: begin
        if (hit < 0) begin
          r.status = STATUS_NOTFOUND;
        end else begin
          // compaction: later entries move down one slot
          for (int i = hit; i + 1 < int'(fill); i++) members[i] = members[i + 1];
          fill--;
          r.slot_index = SLOT_FIELD_W'(hit);
        end
      end
      OP_FIND: begin
        if (hit < 0) r.status = STATUS_NOTFOUND;
        else r.slot_index = SLOT_FIELD_W'(hit);
      end
      default: begin
        r.status = STATUS_BADOP;
      end
    endcase
    if (fill > peak_fill) peak_fill = fill;
    case (r.status)
      STATUS_OK:       n_ok++;
      STATUS_FULL:     n_full++;
      STATUS_DUP:      n_dup++;
      STATUS_NOTFOUND: n_miss++;
      default:         n_badop++;
    endcase
  endtask

  always @(posedge clk) begin : watch
    cst_rsp_t predicted;
    cst_rsp_t want;
    if (rst) begin
      fill = 0;
      expected_rsp_q.delete();
    end else begin
      if (req_valid && !req_stall) begin
        apply_set_op(req, predicted);
        expected_rsp_q.push_back(predicted);
      end
      if (rsp_valid && !rsp_stall) begin
        if (expected_rsp_q.size() == 0) begin
          errors++;
          $display("%0t: response with nothing expected: status %0d slot %0d",
                   $time, rsp.status, rsp.slot_index);
        end else begin
          want = expected_rsp_q.pop_front();
          if (rsp.status !== want.status) begin
            errors++;
            $display("%0t: status mismatch: expected %0d, got %0d",
                     $time, want.status, rsp.status);
          end
          if (rsp.slot_index !== want.slot_index) begin
            errors++;
            $display("%0t: slot mismatch: expected %0d, got %0d",
                     $time, want.slot_index, rsp.slot_index);
          end
        end
      end
    end
    outstanding = expected_rsp_q.size();
  end

endmodule

// ===== sim/testbench.sv =====
// Top of the compacting set table simulation: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module testbench
  import cst_pkg::*;
();

  localparam int RANDOM_ITEMS = 1300;
  localparam int POOL_SIZE    = 160;   // a bit more than capacity, so the table can fill
  localparam int HOLD_START   = 1200;  // receiver cycle where the long hold-off begins
  localparam int HOLD_CYCLES  = 250;

  // Traffic mixes: each biases the operation toward filling, draining or churn.
  typedef enum int {MIX_FILL, MIX_DRAIN, MIX_CHURN} mix_t;
  // Receiver stall patterns.
  typedef enum int {RX_FREE, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_mode_t;

  logic     clk       = 1'b0;
  logic     rst       = 1'b1;
  logic     req_valid = 1'b0;
  logic     rsp_stall = 1'b0;
  cst_req_t req       = '0;
  wire      req_stall;
  wire      rsp_valid;
  cst_rsp_t rsp;

  int unsigned errors, outstanding, n_ok, n_full, n_dup, n_miss, n_badop, peak_fill;

  // Element values to draw from. Most traffic reuses these so that adds collide
  // (duplicates), finds and deletes hit, and the table reaches capacity.
  logic [ELEM_FIELD_W-1:0] value_pool [POOL_SIZE];
  int                      items_sent = 0;
  int                      burst_left = 0;

  always #1 clk = ~clk;

  compacting_set_table DUT (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  cst_checker set_checker (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .req         (req),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .rsp         (rsp),
    .errors      (errors),
    .outstanding (outstanding),
    .n_ok        (n_ok),
    .n_full      (n_full),
    .n_dup       (n_dup),
    .n_miss      (n_miss),
    .n_badop     (n_badop),
    .peak_fill   (peak_fill)
  );

  // One request transaction. The payload goes out at the falling edge and holds
  // until a rising edge sees the DUT not stalling. Valid stays high into the
  // next transaction when there is no gap, so it is assigned once per edge.
  task automatic offer_request(input logic [OP_W-1:0] op,
                               input logic [ELEM_FIELD_W-1:0] elem);
    if (burst_left == 0) begin
      // end of a burst: random gap (often none), then a fresh burst length;
      // long bursts give stretches with no sender idling at all
      repeat ($urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 6)) begin
        @(negedge clk);
        req_valid <= 1'b0;
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                               : $urandom_range(1, 16);
    end
    burst_left--;
    @(negedge clk);
    req_valid <= 1'b1;
    req       <= {op, elem};
    do @(posedge clk); while (req_stall);
    items_sent++;
  endtask

  function automatic logic [OP_W-1:0] pick_operation(input mix_t mix);
    int roll;
    roll = $urandom_range(0, 99);
    case (mix)
      MIX_FILL:  return roll < 85 ? OP_ADD : roll < 93 ? OP_FIND : roll < 97 ? OP_DEL : OP_BAD;
      MIX_DRAIN: return roll < 65 ? OP_DEL : roll < 85 ? OP_FIND : roll < 95 ? OP_ADD : OP_BAD;
      default:   return roll < 35 ? OP_ADD : roll < 65 ? OP_DEL : roll < 95 ? OP_FIND : OP_BAD;
    endcase
  endfunction

  // Mostly pool values; some fully random (almost always misses) and some
  // corner values of the element field.
  function automatic logic [ELEM_FIELD_W-1:0] pick_element();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 80) return value_pool[$urandom_range(0, POOL_SIZE - 1)];
    if (roll < 90) return $urandom;
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return '1;
      2:       return 32'h0000_0001;
      default: return 32'h8000_0000;
    endcase
  endfunction

  // Receiver: stall pattern redrawn from four modes as each run ends, plus
  // one long hold-off while the sender keeps offering, so the output register
  // stays occupied and the DUT has to stall its request side.
  initial begin : receiver
    int       cyc;
    int       mode_left;
    rx_mode_t mode;
    logic     stall_now;
    cyc       = 0;
    mode_left = 0;
    mode      = RX_FREE;
    forever begin
      @(negedge clk);
      cyc++;
      if (mode_left == 0) begin
        mode      = rx_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(64, 256);
      end
      mode_left--;
      case (mode)
        RX_FREE:  stall_now = 1'b0;
        RX_LIGHT: stall_now = ($urandom_range(0, 3) == 0);
        RX_HEAVY: stall_now = ($urandom_range(0, 9) < 7);
        default:  stall_now = (cyc % 3 == 0);
      endcase
      if (cyc >= HOLD_START && cyc < HOLD_START + HOLD_CYCLES) stall_now = 1'b1;
      rsp_stall <= stall_now;
    end
  end

  initial begin : stimulus
    mix_t mix;
    int   phase_len;
    int   random_start;

    for (int i = 0; i < POOL_SIZE; i++) value_pool[i] = $urandom;
    value_pool[0] = '0;
    value_pool[1] = '1;

    // synchronous reset, held from time zero and released at a falling edge
    repeat (6) @(negedge clk);
    rst <= 1'b0;

    // Directed: empty-table lookups, field extremes, duplicate add, delete from
    // the front / middle / end (compaction), and the unused operation code.
    offer_request(OP_FIND, 32'h0000_0000);   // empty table
    offer_request(OP_DEL,  32'hFFFF_FFFF);   // empty table
    offer_request(OP_ADD,  32'h0000_0000);
    offer_request(OP_ADD,  32'hFFFF_FFFF);
    offer_request(OP_ADD,  32'h0000_0000);   // duplicate
    offer_request(OP_FIND, 32'hFFFF_FFFF);
    offer_request(OP_FIND, 32'h1234_5678);   // absent
    offer_request(OP_DEL,  32'h0000_0000);   // front delete, rest shifts down
    offer_request(OP_FIND, 32'hFFFF_FFFF);   // now in slot 0
    offer_request(OP_DEL,  32'h0000_0000);   // already gone
    offer_request(OP_BAD,  32'h0000_0000);
    offer_request(OP_BAD,  32'hFFFF_FFFF);
    offer_request(OP_ADD,  32'h8000_0000);
    offer_request(OP_ADD,  32'h0000_0001);
    offer_request(OP_ADD,  32'h5555_5555);
    offer_request(OP_ADD,  32'hAAAA_AAAA);
    offer_request(OP_DEL,  32'h0000_0001);   // middle delete
    offer_request(OP_FIND, 32'hAAAA_AAAA);
    offer_request(OP_FIND, 32'h5555_5555);
    offer_request(OP_DEL,  32'hAAAA_AAAA);   // last entry
    offer_request(OP_ADD,  32'h0000_0000);   // zero again, appended at the end
    offer_request(OP_FIND, 32'h0000_0000);

    // Random part: an add-heavy opening fills the table to capacity (full
    // status), then phases of random mix drain and refill it.
    random_start = items_sent;
    mix          = MIX_FILL;
    phase_len    = 400;
    while (items_sent - random_start < RANDOM_ITEMS) begin
      // last phase is cut short so the run stops at the item budget
      if (phase_len > RANDOM_ITEMS - (items_sent - random_start))
        phase_len = RANDOM_ITEMS - (items_sent - random_start);
      repeat (phase_len) offer_request(pick_operation(mix), pick_element());
      mix       = mix_t'($urandom_range(0, 2));
      phase_len = $urandom_range(100, 250);
    end

    @(negedge clk);
    req_valid <= 1'b0;

    // drain: wait for every expected response, then watch for strays
    while (outstanding != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Covered %0d set transactions: %0d ok, %0d full, %0d duplicate, %0d not found,",
             items_sent, n_ok, n_full, n_dup, n_miss);
    $display("%0d bad operation; table held up to %0d entries.", n_badop, peak_fill);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // hard stop well beyond the slowest legal run
  initial begin : watchdog
    #1_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/cst_pkg.sv
rtl/cst_cell.sv
rtl/compacting_set_table.sv
sim/cst_checker.sv
sim/testbench.sv
